// ===== src/pqem_pkg.sv =====
// shared types and constants for the stable max-priority queue
package pqem_pkg;

   localparam int DEPTH_DEF = 16;
   localparam int DATA_W    = 32;
   localparam int COUNT_W   = 5;

   typedef enum logic [1:0] {
      ACT_INSERT  = 2'd0,
      ACT_EXTRACT = 2'd1,
      ACT_CLEAR   = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      OP_HOLD,
      OP_INSERT,
      OP_EXTRACT,
      OP_CLEAR
   } cell_op_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic signed [DATA_W-1:0] prio;
   } entry_type;

   typedef struct packed {
      cell_op_type op;
      entry_type   entry;
   } cell_cmd_type;

   typedef struct packed {
      logic [1:0]               action;
      logic signed [DATA_W-1:0] item_value;
      logic signed [DATA_W-1:0] item_priority;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] out_value;
      logic                     got_item;
      logic [1:0]               status;
      logic [COUNT_W-1:0]       count_after;
   } rsp_type;

endpackage

// ===== src/pqem_cell.sv =====
// one slot of the sorted chain: holds an entry, shifts toward or away from the head
module pqem_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  pqem_pkg::cell_cmd_type  cmd,
   input  pqem_pkg::entry_type     left_entry,
   input  logic                    left_valid,
   input  logic                    left_keep,
   input  pqem_pkg::entry_type     right_entry,
   input  logic                    right_valid,
   output logic                    keep,
   output pqem_pkg::entry_type     entry,
   output logic                    valid
);

   pqem_pkg::entry_type entry_ff, entry_in;
   logic                valid_ff, valid_in;

   // entry stays put on insert when it ranks at or above the new one
   assign keep = valid_ff && (entry_ff.prio >= cmd.entry.prio);

   always_comb begin
      entry_in = entry_ff;
      valid_in = valid_ff;
      unique case (cmd.op)
         pqem_pkg::OP_INSERT: begin
            if (!keep) begin
               if (left_keep) begin
                  entry_in = cmd.entry;
                  valid_in = 1'b1;
               end else begin
                  entry_in = left_entry;
                  valid_in = left_valid;
               end
            end
         end
         pqem_pkg::OP_EXTRACT: begin
            entry_in = right_entry;
            valid_in = right_valid;
         end
         pqem_pkg::OP_CLEAR: begin
            valid_in = 1'b0;
         end
         default: begin
            entry_in = entry_ff;
            valid_in = valid_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign entry = entry_ff;
   assign valid = valid_ff;

endmodule

// ===== src/priority_queue_extract_max_top.sv =====
// top level of the stable max-priority queue built as a sorted chain of cells
//
// Bounded max-priority queue of DEPTH (value, priority) pairs kept in a row of
// cells sorted by signed priority, highest at cell 0; among equal priorities the
// earlier insert sits closer to the head, so extract is stable. Each request beat
// carries one action: insert, extract or clear (code 3 does nothing). Every
// request gives exactly one response beat, in the cycle after acceptance, with the
// extracted value (0 if none), got_item, a status (ok, extract from empty, insert
// dropped because full) and the entry count after the action. The chain takes one
// beat per cycle: on insert every cell compares its priority with the new one in
// parallel and either holds, takes the new entry or takes its left neighbor's entry;
// on extract every cell takes its right neighbor's entry. A new request is taken
// whenever the response register is empty or being drained, so throughput is one
// beat per clock as long as rsp_ready stays high. Reset empties the queue at once;
// there is no clearing pass.
module priority_queue_extract_max_top #(
   parameter int DEPTH = pqem_pkg::DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  pqem_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output pqem_pkg::rsp_type rsp_data
);

   localparam int CW = $clog2(DEPTH + 1);

   // chain wiring
   pqem_pkg::entry_type   entry_w [DEPTH];
   logic [DEPTH-1:0]      valid_w;
   logic [DEPTH-1:0]      keep_w;
   pqem_pkg::cell_cmd_type cmd;

   logic [CW-1:0]     count_ff, count_in;
   logic              rsp_valid_ff, rsp_valid_in;
   pqem_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic req_beat;
   logic q_empty;
   logic q_full;

   assign req_beat = req_valid && req_ready;
   assign req_ready = !rsp_valid_ff || rsp_ready;

   // occupancy comes straight from the chain ends
   assign q_empty = !valid_w[0];
   assign q_full  = valid_w[DEPTH-1];

   // decode the action into a chain command and the response
   always_comb begin
      cmd.op      = pqem_pkg::OP_HOLD;
      cmd.entry   = '{value: req_data.item_value, prio: req_data.item_priority};
      count_in    = count_ff;
      rsp_data_in.out_value = '0;
      rsp_data_in.got_item  = 1'b0;
      rsp_data_in.status    = pqem_pkg::ST_OK;
      unique case (req_data.action)
         pqem_pkg::ACT_INSERT: begin
            if (q_full) begin
               rsp_data_in.status = pqem_pkg::ST_FULL;
            end else begin
               cmd.op   = pqem_pkg::OP_INSERT;
               count_in = count_ff + CW'(1);
            end
         end
         pqem_pkg::ACT_EXTRACT: begin
            if (q_empty) begin
               rsp_data_in.status = pqem_pkg::ST_EMPTY;
            end else begin
               // head cell always holds the winner
               cmd.op                = pqem_pkg::OP_EXTRACT;
               count_in              = count_ff - CW'(1);
               rsp_data_in.out_value = entry_w[0].value;
               rsp_data_in.got_item  = 1'b1;
            end
         end
         pqem_pkg::ACT_CLEAR: begin
            cmd.op   = pqem_pkg::OP_CLEAR;
            count_in = '0;
         end
         default: begin
            cmd.op = pqem_pkg::OP_HOLD;
         end
      endcase
      if (!req_beat) begin
         cmd.op   = pqem_pkg::OP_HOLD;
         count_in = count_ff;
      end
      rsp_data_in.count_after = pqem_pkg::COUNT_W'(count_in);
   end

   // the cell chain
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      pqem_pkg::entry_type left_entry, right_entry;
      logic                left_valid, left_keep, right_valid;

      if (i == 0) begin : g_head
         assign left_entry = cmd.entry;
         assign left_valid = 1'b0;
         assign left_keep  = 1'b1;   // new entry lands here when the head does not keep its own
      end else begin : g_body
         assign left_entry = entry_w[i-1];
         assign left_valid = valid_w[i-1];
         assign left_keep  = keep_w[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign right_entry = '0;
         assign right_valid = 1'b0;
      end else begin : g_mid
         assign right_entry = entry_w[i+1];
         assign right_valid = valid_w[i+1];
      end

      pqem_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .cmd         (cmd),
         .left_entry  (left_entry),
         .left_valid  (left_valid),
         .left_keep   (left_keep),
         .right_entry (right_entry),
         .right_valid (right_valid),
         .keep        (keep_w[i]),
         .entry       (entry_w[i]),
         .valid       (valid_w[i])
      );
   end

   // response register decouples the two sides
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_beat) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_beat) begin
         rsp_data_ff <= rsp_data_in;
      end
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   // head occupancy and the counter agree
   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      !valid_w[0] |-> count_ff == '0)
      else $error("empty head with nonzero count");

   a_head_count: assert property (@(posedge clock) disable iff (reset)
      valid_w[0] |-> count_ff != '0)
      else $error("occupied head with zero count");

   // tail cell occupied only when the queue is full
   a_tail_full: assert property (@(posedge clock) disable iff (reset)
      valid_w[DEPTH-1] |-> count_ff == CW'(DEPTH))
      else $error("tail occupied but count not full");

   // a clear beat empties the chain
   a_clear: assert property (@(posedge clock) disable iff (reset)
      req_beat && req_data.action == pqem_pkg::ACT_CLEAR |=> valid_w == '0)
      else $error("chain not empty after clear");

   // a returned item always carries status ok
   a_got_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.got_item |-> rsp_data_ff.status == pqem_pkg::ST_OK)
      else $error("got_item with error status");
`endif

endmodule

// ===== dv/tb.sv =====
// self-checking testbench for the stable max-priority queue top level
`timescale 1ns / 100ps

module tb;
   import pqem_pkg::*;

   localparam int QUEUE_DEPTH = DEPTH_DEF;

   // no package member exists for the spare action code
   localparam logic [1:0] ACT_NOP = 2'd3;

   localparam logic signed [DATA_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [DATA_W-1:0] WORD_MIN = 32'sh8000_0000;

   // cycles with no beat on either channel before the run is called hung
   localparam int STALL_LIMIT = 2000;
   localparam int RAND_PER_PHASE = 440;
   localparam int DIR_ROWS = 15;

   // one row of the directed stimulus; typed rows carry their expected response
   typedef struct packed {
      logic [1:0]               action;
      logic signed [DATA_W-1:0] value;
      logic signed [DATA_W-1:0] prio;
      logic [4:0]               reps;
      logic                     rand_fill;
      logic                     typed;
      logic signed [DATA_W-1:0] exp_value;
      logic                     exp_got;
      logic [1:0]               exp_status;
      logic [COUNT_W-1:0]       exp_count;
   } dir_row_type;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   priority_queue_extract_max_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // directed table: empty and spare-code cases, extreme words, a tie at the
   // top priority, a fill to capacity and a dropped insert on a full queue
   dir_row_type dir_table [DIR_ROWS] = '{
      '{ACT_EXTRACT, 32'sd0,   32'sd0,   5'd1,  1'b0, 1'b1, 32'sd0,   1'b0, ST_EMPTY, 5'd0},
      '{ACT_NOP,     32'sd0,   32'sd0,   5'd1,  1'b0, 1'b1, 32'sd0,   1'b0, ST_OK,    5'd0},
      '{ACT_INSERT,  WORD_MAX, WORD_MIN, 5'd1,  1'b0, 1'b1, 32'sd0,   1'b0, ST_OK,    5'd1},
      '{ACT_INSERT,  WORD_MIN, WORD_MAX, 5'd1,  1'b0, 1'b1, 32'sd0,   1'b0, ST_OK,    5'd2},
      '{ACT_INSERT,  -32'sd1,  WORD_MAX, 5'd1,  1'b0, 1'b1, 32'sd0,   1'b0, ST_OK,    5'd3},
      '{ACT_INSERT,  32'sd0,   32'sd0,   5'd1,  1'b0, 1'b1, 32'sd0,   1'b0, ST_OK,    5'd4},
      '{ACT_EXTRACT, 32'sd0,   32'sd0,   5'd1,  1'b0, 1'b1, WORD_MIN, 1'b1, ST_OK,    5'd3},
      '{ACT_EXTRACT, 32'sd0,   32'sd0,   5'd1,  1'b0, 1'b1, -32'sd1,  1'b1, ST_OK,    5'd2},
      '{ACT_EXTRACT, 32'sd0,   32'sd0,   5'd1,  1'b0, 1'b1, 32'sd0,   1'b1, ST_OK,    5'd1},
      '{ACT_NOP,     WORD_MAX, WORD_MAX, 5'd1,  1'b0, 1'b1, 32'sd0,   1'b0, ST_OK,    5'd1},
      '{ACT_CLEAR,   32'sd0,   32'sd0,   5'd1,  1'b0, 1'b1, 32'sd0,   1'b0, ST_OK,    5'd0},
      '{ACT_INSERT,  32'sd0,   32'sd0,   5'd16, 1'b1, 1'b0, 32'sd0,   1'b0, ST_OK,    5'd0},
      '{ACT_INSERT,  WORD_MAX, WORD_MAX, 5'd1,  1'b0, 1'b1, 32'sd0,   1'b0, ST_FULL,  5'd16},
      '{ACT_EXTRACT, 32'sd0,   32'sd0,   5'd1,  1'b0, 1'b0, 32'sd0,   1'b0, ST_OK,    5'd0},
      '{ACT_CLEAR,   32'sd0,   32'sd0,   5'd1,  1'b0, 1'b1, 32'sd0,   1'b0, ST_OK,    5'd0}
   };

   // shadow copy of the queue contents, in insertion order
   logic signed [DATA_W-1:0] held_value [QUEUE_DEPTH];
   logic signed [DATA_W-1:0] held_prio  [QUEUE_DEPTH];
   int                       held_count;

   rsp_type pending_rsp [$];
   rsp_type want_rsp;

   int send_idle_pct;
   int recv_idle_pct;
   int fail_count;
   int stall_cycles;

   // what the run reached, for the closing summary
   int n_inserts;
   int n_drops;
   int n_hits;
   int n_empty;
   int n_clears;
   int n_spare;

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // apply one request beat to the shadow queue and return the response it must give
   function automatic rsp_type queue_step(input req_type beat);
      rsp_type res;
      int      best;
      res = '0;
      res.status = ST_OK;
      case (beat.action)
         ACT_INSERT: begin
            if (held_count >= QUEUE_DEPTH) begin
               res.status = ST_FULL;
               n_drops++;
            end else begin
               held_value[held_count] = beat.item_value;
               held_prio[held_count]  = beat.item_priority;
               held_count++;
               n_inserts++;
            end
         end
         ACT_EXTRACT: begin
            if (held_count == 0) begin
               res.status = ST_EMPTY;
               n_empty++;
            end else begin
               // strictly greater keeps the oldest of equal priorities
               best = 0;
               for (int i = 1; i < held_count; i++)
                  if (held_prio[i] > held_prio[best]) best = i;
               res.out_value = held_value[best];
               res.got_item  = 1'b1;
               for (int i = best; i < held_count - 1; i++) begin
                  held_value[i] = held_value[i+1];
                  held_prio[i]  = held_prio[i+1];
               end
               held_count--;
               n_hits++;
            end
         end
         ACT_CLEAR: begin
            held_count = 0;
            n_clears++;
         end
         default: n_spare++;
      endcase
      res.count_after = COUNT_W'(held_count);
      return res;
   endfunction

   function automatic logic signed [DATA_W-1:0] corner_word();
      case ($urandom_range(3))
         0:       return WORD_MAX;
         1:       return WORD_MIN;
         2:       return 32'sd0;
         default: return -32'sd1;
      endcase
   endfunction

   // random request; priorities lean on a narrow band so that ties are common
   function automatic req_type random_beat(input int insert_pct);
      req_type beat;
      int      pick;
      pick = $urandom_range(99);
      if (pick < insert_pct)  beat.action = ACT_INSERT;
      else if (pick < 95)     beat.action = ACT_EXTRACT;
      else if (pick < 98)     beat.action = ACT_CLEAR;
      else                    beat.action = ACT_NOP;
      if ($urandom_range(4) == 0) beat.item_value = corner_word();
      else                        beat.item_value = $urandom;
      case ($urandom_range(9))
         0, 1:    beat.item_priority = corner_word();
         2, 3, 4: beat.item_priority = $urandom;
         default: beat.item_priority = $urandom_range(7) - 4;
      endcase
      return beat;
   endfunction

   // drive one beat from a falling edge, wait for the handshake, log what it must give
   task automatic send_beat(input req_type beat, input logic use_typed,
                            input rsp_type typed_rsp);
      rsp_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      // shadow state always follows, even where the row types its own answer
      predicted = queue_step(beat);
      pending_rsp.push_back(use_typed ? typed_rsp : predicted);
      @(negedge clock);
   endtask

   // hold the request side off until every outstanding response is back
   task automatic drain_responses();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_rsp.size() != 0) @(negedge clock);
   endtask

   // receiver stalls at its own rate, changed on the falling edge
   always @(negedge clock) rsp_ready <= ($urandom_range(99) >= recv_idle_pct);

   // response checker: every accepted beat against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsp.size() == 0) begin
            $error("response beat with no request outstanding");
            fail_count++;
         end else begin
            want_rsp = pending_rsp.pop_front();
            if (rsp_data.out_value !== want_rsp.out_value) begin
               $error("out_value: expected %0d, got %0d",
                      want_rsp.out_value, rsp_data.out_value);
               fail_count++;
            end
            if (rsp_data.got_item !== want_rsp.got_item) begin
               $error("got_item: expected %0d, got %0d",
                      want_rsp.got_item, rsp_data.got_item);
               fail_count++;
            end
            if (rsp_data.status !== want_rsp.status) begin
               $error("status: expected %0d, got %0d",
                      want_rsp.status, rsp_data.status);
               fail_count++;
            end
            if (rsp_data.count_after !== want_rsp.count_after) begin
               $error("count_after: expected %0d, got %0d",
                      want_rsp.count_after, rsp_data.count_after);
               fail_count++;
            end
         end
      end
   end

   // watchdog: too long without a beat on either channel means a hang
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("no beat for %0d cycles, %0d responses outstanding",
                  STALL_LIMIT, pending_rsp.size());
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      req_type     beat;
      rsp_type     typed_rsp;
      dir_row_type row;
      int          insert_pct;

      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data      = '0;
      rsp_ready     = 1'b0;
      held_count    = 0;
      fail_count    = 0;
      stall_cycles  = 0;
      n_inserts     = 0;
      n_drops       = 0;
      n_hits        = 0;
      n_empty       = 0;
      n_clears      = 0;
      n_spare       = 0;
      send_idle_pct = 28;
      recv_idle_pct = 85;
      insert_pct    = 50;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed part, under the first idling mix
      for (int r = 0; r < DIR_ROWS; r++) begin
         row = dir_table[r];
         typed_rsp.out_value   = row.exp_value;
         typed_rsp.got_item    = row.exp_got;
         typed_rsp.status      = row.exp_status;
         typed_rsp.count_after = row.exp_count;
         for (int k = 0; k < row.reps; k++) begin
            if (row.rand_fill) begin
               beat = random_beat(insert_pct);
               beat.action = row.action;
            end else begin
               beat.action        = row.action;
               beat.item_value    = row.value;
               beat.item_priority = row.prio;
            end
            send_beat(beat, row.typed, typed_rsp);
         end
      end

      // random part: slow receiver, then slow sender, then full rate both ways
      for (int ph = 0; ph < 3; ph++) begin
         drain_responses();
         case (ph)
            0: begin send_idle_pct = 28; recv_idle_pct = 85; end
            1: begin send_idle_pct = 85; recv_idle_pct = 28; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         for (int n = 0; n < RAND_PER_PHASE; n++) begin
            // insert-heavy runs fill the queue, extract-heavy runs empty it
            if (n % 40 == 0) begin
               case ($urandom_range(2))
                  0:       insert_pct = 20;
                  1:       insert_pct = 50;
                  default: insert_pct = 85;
               endcase
            end
            send_beat(random_beat(insert_pct), 1'b0, '0);
            if ($urandom_range(99) == 0) drain_responses();
         end
      end

      drain_responses();
      // a late stray response would still be caught here
      repeat (8) @(posedge clock);

      $display("inserts %0d, dropped on full %0d, extracts with item %0d, on empty %0d",
               n_inserts, n_drops, n_hits, n_empty);
      $display("clears %0d, spare action code %0d, over three idling mixes",
               n_clears, n_spare);
      if (fail_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

// ===== priority_queue_extract_max_top.f =====
src/pqem_pkg.sv
src/pqem_cell.sv
src/priority_queue_extract_max_top.sv
dv/tb.sv
